### rtl/assert_macros.svh
// Assertion macros for the message ring queue files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/bmrq_pkg.sv
// Shared constants, types and helper functions of the message ring queue.
package bmrq_pkg;

	localparam int SLOTS     = 16;
	localparam int MAX_BYTES = 64;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int LEN_W     = 7;
	localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int DEPTH     = SLOTS * MAX_BYTES;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int STAT_W    = 3;

	localparam logic [STAT_W-1:0] ST_SUCCESS   = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data_byte;
		logic             last_byte;
		logic [LEN_W-1:0] max_read;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [7:0]        data_byte_out;
		logic [LEN_W-1:0]  message_length;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic send_en;
		logic recv_status_en;
		logic recv_start;
		logic rd_en;
	} ctrl_t;

	typedef struct packed {
		logic recv_stream;
		logic rd_final;
	} stat_t;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot);
		logic [SLOT_W-1:0] res;
		if (slot == SLOT_W'(SLOTS - 1)) begin
			res = '0;
		end else begin
			res = slot + SLOT_W'(1);
		end
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(slot) * ADDR_W'(MAX_BYTES) + ADDR_W'(idx);
	endfunction

endpackage

### rtl/bmrq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bmrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/bmrq_ctrl.sv
// Controller state machine of the message ring queue.
module bmrq_ctrl
	import bmrq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  kind,
	input  stat_t stat,
	output logic  busy,
	output ctrl_t ctrl
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		ctrl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!kind) begin
						ctrl.send_en = 1'b1;
					end else if (stat.recv_stream) begin
						ctrl.recv_start = 1'b1;
						state_nx        = S_READ;
					end else begin
						ctrl.recv_status_en = 1'b1;
					end
				end
			end
			S_READ: begin
				ctrl.rd_en = 1'b1;
				if (stat.rd_final) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

### rtl/bmrq_dp.sv
// Datapath of the message ring queue: ring pointers, slot lengths, byte store and result register.
module bmrq_dp
	import bmrq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  ctrl_t ctrl,
	output stat_t stat,
	output logic  done,
	output rsp_t  rsp
);

	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  len_q [SLOTS];
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic              res_valid_q;
	rsp_t              res_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  rd_len_q;
	logic              rd_valid_s1;
	logic              rd_last_s1;

	logic              full;
	logic              empty;
	logic              room;
	logic              ovf_nx;
	logic [CNT_W-1:0]  cnt_nx;
	logic [CNT_W-1:0]  head_len;
	logic [CNT_W-1:0]  n_sel;
	logic [STAT_W-1:0] send_st;
	logic [STAT_W-1:0] recv_st;
	logic [7:0]        ram_rdata;

	always_comb begin
		full   = (slot_next(tail_q) == head_q);
		empty  = (head_q == tail_q);
		room   = (cnt_q < CNT_W'(MAX_BYTES));
		ovf_nx = ovf_q | ~room;
		cnt_nx = room ? (cnt_q + CNT_W'(1)) : cnt_q;

		head_len = len_q[head_q];
		if (head_len > CNT_W'(MAX_BYTES)) begin
			head_len = CNT_W'(MAX_BYTES);
		end
		if (CMP_W'(req.max_read) < CMP_W'(head_len)) begin
			n_sel = CNT_W'(req.max_read);
		end else begin
			n_sel = head_len;
		end

		if (full) begin
			send_st = ST_FULL;
		end else if (ovf_nx) begin
			send_st = ST_TOO_LARGE;
		end else begin
			send_st = ST_SUCCESS;
		end

		if (req.max_read == '0) begin
			recv_st = ST_INVALID;
		end else if (empty) begin
			recv_st = ST_EMPTY;
		end else begin
			recv_st = ST_SUCCESS;
		end

		stat.recv_stream = (req.max_read != '0) && !empty && (n_sel != '0);
		stat.rd_final    = ((rd_idx_q + CNT_W'(1)) == n_q);
	end

	bmrq_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctrl.send_en && room),
		.waddr (byte_addr(tail_q, cnt_q[IDX_W-1:0])),
		.wdata (req.data_byte),
		.re    (ctrl.rd_en),
		.raddr (byte_addr(rd_slot_q, rd_idx_q[IDX_W-1:0])),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			res_valid_q <= (ctrl.send_en && req.last_byte) || ctrl.recv_status_en;
			rd_valid_s1 <= ctrl.rd_en;
			rd_last_s1  <= ctrl.rd_en && stat.rd_final;

			if (ctrl.send_en) begin
				if (req.last_byte) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
					if (send_st == ST_SUCCESS) begin
						len_q[tail_q] <= cnt_nx;
						tail_q        <= slot_next(tail_q);
					end
				end else begin
					cnt_q <= cnt_nx;
					ovf_q <= ovf_nx;
				end
			end

			if (ctrl.recv_status_en) begin
				if (recv_st == ST_SUCCESS) begin
					head_q <= slot_next(head_q);
				end
			end

			if (ctrl.recv_start) begin
				head_q   <= slot_next(head_q);
				rd_idx_q <= '0;
			end else if (ctrl.rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.send_en && req.last_byte) begin
			res_q.status         <= send_st;
			res_q.data_byte_out  <= '0;
			res_q.message_length <= '0;
			res_q.last           <= 1'b1;
		end else if (ctrl.recv_status_en) begin
			res_q.status         <= recv_st;
			res_q.data_byte_out  <= '0;
			res_q.message_length <= (recv_st == ST_SUCCESS) ? LEN_W'(head_len) : '0;
			res_q.last           <= 1'b1;
		end
		if (ctrl.recv_start) begin
			rd_slot_q <= head_q;
			n_q       <= n_sel;
			rd_len_q  <= head_len;
		end
	end

	always_comb begin
		done = res_valid_q | rd_valid_s1;
		if (rd_valid_s1) begin
			rsp.status         = ST_SUCCESS;
			rsp.data_byte_out  = ram_rdata;
			rsp.message_length = LEN_W'(rd_len_q);
			rsp.last           = rd_last_s1;
		end else begin
			rsp = res_q;
		end
	end

endmodule

### rtl/bounded_message_ring_queue_unit.sv
// Top level of the bounded message ring queue.
//
// A transaction is taken at a rising edge where start is high and busy is low; req
// carries either one byte of a message being sent (kind low) or a receive request.
// Send bytes are taken one per cycle and busy stays low while a message is gathered.
// An unmarked send byte gives no result. A marked send byte gives one status result
// in the cycle after it is taken: success, full or too large.
// A receive with a zero buffer size, or on an empty ring, gives one status result in
// the next cycle. Otherwise the head message is read from the byte store, one byte
// per cycle: the request moves the controller to its read state, where each byte is
// read into the registered read port of the byte store and then shown; the bytes
// follow back to back, and busy stays high until the final byte, marked by last,
// has been shown.
// Each result is presented on rsp for exactly one cycle with done high; the receiver
// cannot stall, so results are never held.
// Reset empties the ring and clears the send in progress; the byte store itself is
// not cleared and needs no clearing pass.
`include "assert_macros.svh"

module bounded_message_ring_queue_unit
	import bmrq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	ctrl_t ctrl;
	stat_t stat;

	bmrq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	bmrq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctrl   (ctrl),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

	`ASSERT_NEXT(a_recv_answers, clk, arst_n, start && !busy && req.kind, done || busy)
	`ASSERT_NEXT(a_send_silent, clk, arst_n, start && !busy && !req.kind && !req.last_byte, !done)
	`ASSERT_SAME(a_status_clean, clk, arst_n, done && (rsp.status != ST_SUCCESS), (rsp.data_byte_out == 8'd0) && (rsp.message_length == '0) && rsp.last)
	`ASSERT_SAME(a_read_busy, clk, arst_n, ctrl.rd_en, busy)

endmodule
